@@ hw/rtl/cbspi_pkg.sv @@
// Shared types and constants for the cartridge bank / serial flash controller.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package cbspi_pkg;

    localparam int BANK_BITS_DEF = 11;
    localparam int BANK_W        = 11;   // width of the reported bank field
    localparam int ROM_ADDR_W    = 24;
    localparam int ROM_OFS_W     = 13;   // 8 KiB window inside a bank

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    localparam logic [7:0] IO_CTRL_ADDR = 8'h08;

    typedef enum logic [1:0] {
        FUNC_IO_WR  = 2'd0,
        FUNC_IO_RD  = 2'd1,
        FUNC_ROM_LO = 2'd2,
        FUNC_ROM_HI = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_FLASH  = 2'd1,
        SRC_VECTOR = 2'd2,
        SRC_MEM    = 2'd3
    } t_source;

    typedef enum logic [1:0] {
        MODE_GAME8K  = 2'd0,
        MODE_ULTIMAX = 2'd1,
        MODE_OFF     = 2'd2
    } t_mode;

    // CPU port configurations that still map the cartridge at low ROM
    localparam logic [2:0] MCFG_ALL_ROM = 3'd7;
    localparam logic [2:0] MCFG_IO_ROM  = 3'd3;

    // fixed reset/irq vector bytes served at the top eight addresses
    function automatic logic [7:0] vec_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h08;
            3'd1:    b = 8'h00;
            3'd2:    b = 8'h08;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0c;
            3'd5:    b = 8'h80;
            3'd6:    b = 8'h0c;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cartridge_bank_spi_bitbang_ctrl.sv @@
// Cartridge controller: bank register, bit-banged flash pins, ROM address mapping.
// Depends on cbspi_pkg.
// Items pass an input register, then a result register; throughput is one item per cycle
// while results are taken; while a result waits the input register takes one more.
// State (bank, flags, mode, pin latches) updates as an item moves into the result register.
// Synchronous active-low reset: chip select deselected, control state cleared, no item held.
`default_nettype none

module cartridge_bank_spi_bitbang_ctrl #(
    parameter int BANK_BITS = cbspi_pkg::BANK_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // addr[15:0], wdata[23:16], flash_dout[24], cpu_cfg[27:25], zero pad
    input  wire logic [cbspi_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func[1:0]
    input  wire logic [cbspi_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // rdata[7:0], rom_addr[31:8], flash_cs[32], flash_clk[33], flash_din[34],
    // map_mode[36:35], cur_bank[47:37]
    output logic [cbspi_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // rdata_valid[0], source[2:1]
    output logic [cbspi_pkg::M_TUSER_W-1:0]      o_m_tuser
);
    import cbspi_pkg::*;

    // input register
    logic        r_in_valid;
    t_func       r_in_func;
    logic [15:0] r_in_addr;
    logic [7:0]  r_in_wdata;
    logic        r_in_dout;
    logic [2:0]  r_in_mcfg;

    // block state
    logic [BANK_BITS-1:0] r_bank, n_bank;
    logic  r_bitbang, n_bitbang;
    logic  r_vectors, n_vectors;
    t_mode r_mode, n_mode;
    logic  r_cs, n_cs;
    logic  r_clk_l, n_clk_l;
    logic  r_din_l, n_din_l;
    logic  r_clk_pin, n_clk_pin;
    logic  r_din_pin, n_din_pin;

    // result register
    logic                  r_out_valid;
    logic [7:0]            r_out_rdata, n_rdata;
    logic                  r_out_rvalid, n_rvalid;
    t_source               r_out_source, n_source;
    logic [ROM_ADDR_W-1:0] r_out_rom_addr, n_rom_addr;

    logic              move;
    logic [7:0]        a8;
    logic [BANK_W-1:0] bank_ext;

    assign move       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || move;
    assign a8         = r_in_addr[7:0];
    assign bank_ext   = BANK_W'(r_bank);

    always_comb begin
        n_bank     = r_bank;
        n_bitbang  = r_bitbang;
        n_vectors  = r_vectors;
        n_mode     = r_mode;
        n_cs       = r_cs;
        n_clk_l    = r_clk_l;
        n_din_l    = r_din_l;
        n_clk_pin  = r_clk_pin;
        n_din_pin  = r_din_pin;
        n_rdata    = '0;
        n_rvalid   = 1'b0;
        n_source   = SRC_NONE;
        n_rom_addr = '0;

        unique case (r_in_func)
            FUNC_IO_WR: begin
                if (a8[7:3] == 5'd0) begin
                    if (r_bitbang) begin
                        n_cs    = r_in_wdata[6];
                        n_clk_l = r_in_wdata[5];
                        n_din_l = r_in_wdata[4];
                    end else begin
                        // upper bank bits come from the low address bits
                        n_bank = BANK_BITS'({a8[2:0], r_in_wdata});
                    end
                end else if (a8 == IO_CTRL_ADDR) begin
                    n_bitbang = r_in_wdata[7];
                    n_vectors = r_in_wdata[5];
                    if (r_in_wdata[6])
                        n_mode = MODE_OFF;
                    else if (r_in_wdata[5])
                        n_mode = MODE_ULTIMAX;
                    else
                        n_mode = MODE_GAME8K;
                end
                // pins follow the latches whenever the flash is selected
                if (!n_cs) begin
                    n_clk_pin = n_clk_l;
                    n_din_pin = n_din_l;
                end
            end
            FUNC_IO_RD: begin
                if (r_bitbang) begin
                    if (!r_cs) begin
                        n_rvalid = 1'b1;
                        n_rdata  = {r_in_dout, 7'd0};
                    end
                end else if (a8[7:3] == 5'd0) begin
                    n_rvalid = 1'b1;
                    n_rdata  = bank_ext[7:0];
                end else if (a8[7:4] == 4'd0) begin
                    n_rvalid = 1'b1;
                    n_rdata  = 8'(bank_ext[BANK_W-1:8]);
                end
            end
            FUNC_ROM_LO: begin
                if (!r_vectors || r_in_mcfg == MCFG_ALL_ROM || r_in_mcfg == MCFG_IO_ROM) begin
                    n_source   = SRC_FLASH;
                    n_rom_addr = {bank_ext, r_in_addr[ROM_OFS_W-1:0]};
                end else begin
                    n_source = SRC_MEM;
                end
            end
            FUNC_ROM_HI: begin
                if (&r_in_addr[15:3]) begin
                    n_source = SRC_VECTOR;
                    n_rdata  = vec_byte(r_in_addr[2:0]);
                end else begin
                    n_source = SRC_MEM;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bank      <= '0;
            r_bitbang   <= 1'b0;
            r_vectors   <= 1'b0;
            r_mode      <= MODE_GAME8K;
            r_cs        <= 1'b1;
            r_clk_l     <= 1'b0;
            r_din_l     <= 1'b0;
            r_clk_pin   <= 1'b0;
            r_din_pin   <= 1'b0;
        end else begin
            if (o_s_tready)
                r_in_valid <= i_s_tvalid;
            if (move) begin
                r_out_valid <= 1'b1;
                r_bank      <= n_bank;
                r_bitbang   <= n_bitbang;
                r_vectors   <= n_vectors;
                r_mode      <= n_mode;
                r_cs        <= n_cs;
                r_clk_l     <= n_clk_l;
                r_din_l     <= n_din_l;
                r_clk_pin   <= n_clk_pin;
                r_din_pin   <= n_din_pin;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_func  <= t_func'(i_s_tuser);
            r_in_addr  <= i_s_tdata[15:0];
            r_in_wdata <= i_s_tdata[23:16];
            r_in_dout  <= i_s_tdata[24];
            r_in_mcfg  <= i_s_tdata[27:25];
        end
        if (move) begin
            r_out_rdata    <= n_rdata;
            r_out_rvalid   <= n_rvalid;
            r_out_source   <= n_source;
            r_out_rom_addr <= n_rom_addr;
        end
    end

    // state registers only change on a move, so they match the held result
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {bank_ext, r_mode, r_din_pin, r_clk_pin, r_cs,
                         r_out_rom_addr, r_out_rdata};
    assign o_m_tuser  = {r_out_source, r_out_rvalid};

endmodule

`default_nettype wire

@@ hw/rtl/cbspi_checker.sv @@
// Port-level checks for the cartridge controller, bound to the top level.
// Depends on cbspi_pkg and cartridge_bank_spi_bitbang_ctrl.
`default_nettype none

module cbspi_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [cbspi_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire logic [cbspi_pkg::M_TUSER_W-1:0] o_m_tuser
);
    import cbspi_pkg::*;

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // answered io reads never carry a ROM source
    a_rvalid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tuser[2:1] == SRC_NONE)
        else $error("rdata_valid with nonzero source");

    // flash address only shown for flash reads
    a_rom_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2:1] != SRC_FLASH |-> o_m_tdata[31:8] == '0)
        else $error("rom_addr nonzero without flash source");

    // pins only move while selected
    a_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[32] && $past(o_m_tvalid) && $past(o_m_tdata[32])
        |-> $stable(o_m_tdata[34:33]))
        else $error("flash pins changed while deselected");

endmodule

bind cartridge_bank_spi_bitbang_ctrl cbspi_checker u_cbspi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

@@ tb/cartridge_bank_spi_bitbang_ctrl_test.sv @@
// Self-checking bench for the cartridge bank / serial flash controller.
// Random stream traffic with stalls on both sides, checked against a local model.
// Depends on cbspi_pkg and cartridge_bank_spi_bitbang_ctrl.

module cartridge_bank_spi_bitbang_ctrl_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cbspi_pkg::*;

    localparam int BANK_BITS = BANK_BITS_DEF;
    localparam logic [BANK_W-1:0] BANK_MASK = BANK_W'((1 << BANK_BITS) - 1);
    localparam logic [7:0] VECTOR_ROM [8] = '{8'h08, 8'h00, 8'h08, 8'h00,
                                              8'h0c, 8'h80, 8'h0c, 8'h00};
    localparam int RANDOM_ITEMS = 1550;

    typedef struct {
        t_func       func;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        dout;
        logic [2:0]  mcfg;
        int unsigned gap;
        bit          drain;     // hold this item until every result is back
    } t_bus_access;

    typedef struct packed {
        logic [7:0]            rdata;
        logic                  rvalid;
        t_source               source;
        logic [ROM_ADDR_W-1:0] rom_addr;
        logic                  cs;
        logic                  sck;
        logic                  din;
        t_mode                 mode;
        logic [BANK_W-1:0]     bank;
    } t_cart_result;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    cartridge_bank_spi_bitbang_ctrl #(
        .BANK_BITS(BANK_BITS)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tuser (m_tuser)
    );

    always #1 clk = ~clk;

    t_bus_access  access_queue[$];
    t_cart_result results_due[$];
    int unsigned  mismatch_count = 0;
    int unsigned  result_index = 0;
    int unsigned  gap_max = 0;

    // controller model state
    logic [BANK_W-1:0] bank = '0;
    logic              bb_on = 1'b0;
    logic              vec_on = 1'b0;
    t_mode             mode = MODE_GAME8K;
    logic              cs_l = 1'b1;
    logic              sck_l = 1'b0;
    logic              din_l = 1'b0;
    logic              sck_p = 1'b0;
    logic              din_p = 1'b0;

    function automatic t_cart_result cart_access(input t_func fn, input logic [15:0] addr,
                                                 input logic [7:0] wdata, input logic dout,
                                                 input logic [2:0] mcfg);
        t_cart_result r;
        logic [7:0] a8;
        a8 = addr[7:0];
        r = '0;
        case (fn)
            FUNC_IO_WR: begin
                if (a8 <= 8'd7) begin
                    if (bb_on) begin
                        cs_l  = wdata[6];
                        sck_l = wdata[5];
                        din_l = wdata[4];
                    end else begin
                        bank = {a8[2:0], wdata} & BANK_MASK;
                    end
                end else if (a8 == IO_CTRL_ADDR) begin
                    bb_on  = wdata[7];
                    vec_on = wdata[5];
                    if (wdata[6])
                        mode = MODE_OFF;
                    else
                        mode = vec_on ? MODE_ULTIMAX : MODE_GAME8K;
                end
                // pins follow the latches only while the flash is selected
                if (!cs_l) begin
                    sck_p = sck_l;
                    din_p = din_l;
                end
            end
            FUNC_IO_RD: begin
                if (bb_on) begin
                    if (!cs_l) begin
                        r.rvalid = 1'b1;
                        r.rdata  = {dout, 7'd0};
                    end
                end else if (a8 <= 8'd7) begin
                    r.rvalid = 1'b1;
                    r.rdata  = bank[7:0];
                end else if (a8 <= 8'd15) begin
                    r.rvalid = 1'b1;
                    r.rdata  = {5'd0, bank[10:8]};
                end
            end
            FUNC_ROM_LO: begin
                if (!vec_on || mcfg == MCFG_ALL_ROM || mcfg == MCFG_IO_ROM) begin
                    r.source   = SRC_FLASH;
                    r.rom_addr = {bank & BANK_MASK, addr[ROM_OFS_W-1:0]};
                end else begin
                    r.source = SRC_MEM;
                end
            end
            default: begin
                if (addr >= 16'hfff8) begin
                    r.source = SRC_VECTOR;
                    r.rdata  = VECTOR_ROM[addr[2:0]];
                end else begin
                    r.source = SRC_MEM;
                end
            end
        endcase
        r.cs  = cs_l;
        r.sck = sck_p;
        r.din = din_p;
        r.mode = mode;
        r.bank = bank;
        return r;
    endfunction

    function automatic void note_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want !== got) begin
            if (mismatch_count < 10)
                $display("result %0d: %s expected %0h, got %0h", result_index, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic queue_access(input t_func fn, input logic [15:0] addr,
                                input logic [7:0] wdata, input logic dout,
                                input logic [2:0] mcfg);
        t_bus_access a;
        a.func  = fn;
        a.addr  = addr;
        a.wdata = wdata;
        a.dout  = dout;
        a.mcfg  = mcfg;
        a.gap   = $urandom_range(0, gap_max);
        a.drain = (access_queue.size() % 500 == 499);
        access_queue.push_back(a);
    endtask

    // pin_mode keeps writes on the pin latches and mostly selects the flash
    task automatic queue_random_access(input bit pin_mode);
        t_func       fn;
        logic [15:0] addr;
        logic [7:0]  wdata;
        fn    = t_func'($urandom_range(0, 3));
        addr  = 16'($urandom);
        wdata = 8'($urandom);
        case (fn)
            FUNC_IO_WR: begin
                if (pin_mode) begin
                    addr[7:0] = 8'($urandom_range(0, 7));
                    wdata[6]  = ($urandom_range(0, 5) == 0);
                end else if ($urandom_range(0, 4) != 0) begin
                    addr[7:0] = 8'($urandom_range(0, 15));
                end
            end
            FUNC_IO_RD: begin
                if ($urandom_range(0, 3) != 0)
                    addr[7:0] = 8'($urandom_range(0, 15));
            end
            FUNC_ROM_HI: begin
                if ($urandom_range(0, 2) == 0)
                    addr = 16'hfff0 + 16'($urandom_range(0, 15));
            end
            default: ;
        endcase
        queue_access(fn, addr, wdata, 1'($urandom), 3'($urandom));
    endtask

    // acceptance flags, seen at the rising edge and used at the falling edge
    logic s_took = 1'b0;
    logic m_took = 1'b0;

    always @(posedge clk) begin : scoreboard
        t_cart_result seen;
        t_cart_result due;
        s_took <= rst_n && s_tvalid && s_tready;
        m_took <= rst_n && m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready) begin
            seen.rdata    = m_tdata[7:0];
            seen.rom_addr = m_tdata[31:8];
            seen.cs       = m_tdata[32];
            seen.sck      = m_tdata[33];
            seen.din      = m_tdata[34];
            seen.mode     = t_mode'(m_tdata[36:35]);
            seen.bank     = m_tdata[47:37];
            seen.rvalid   = m_tuser[0];
            seen.source   = t_source'(m_tuser[2:1]);
            if (results_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("result %0d: arrived with nothing outstanding", result_index);
                mismatch_count++;
            end else begin
                due = results_due.pop_front();
                note_field("rdata", 32'(due.rdata), 32'(seen.rdata));
                note_field("rdata_valid", 32'(due.rvalid), 32'(seen.rvalid));
                note_field("source", 32'(due.source), 32'(seen.source));
                note_field("rom_addr", 32'(due.rom_addr), 32'(seen.rom_addr));
                note_field("flash_cs", 32'(due.cs), 32'(seen.cs));
                note_field("flash_clk", 32'(due.sck), 32'(seen.sck));
                note_field("flash_din", 32'(due.din), 32'(seen.din));
                note_field("map_mode", 32'(due.mode), 32'(seen.mode));
                note_field("cur_bank", 32'(due.bank), 32'(seen.bank));
            end
            result_index++;
        end
        if (rst_n && s_tvalid && s_tready)
            results_due.push_back(cart_access(t_func'(s_tuser), s_tdata[15:0], s_tdata[23:16],
                                              s_tdata[24], s_tdata[27:25]));
    end

    // sender
    t_bus_access next_access;
    bit          staged = 1'b0;

    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (!staged && access_queue.size() != 0) begin
                next_access = access_queue.pop_front();
                staged = 1'b1;
            end
            if (staged && next_access.gap == 0 &&
                !(next_access.drain && results_due.size() != 0)) begin
                s_tdata  <= {4'd0, next_access.mcfg, next_access.dout,
                             next_access.wdata, next_access.addr};
                s_tuser  <= next_access.func;
                s_tvalid <= 1'b1;
                staged = 1'b0;
            end else begin
                s_tvalid <= 1'b0;
                if (staged && next_access.gap != 0)
                    next_access.gap--;
            end
        end
    end

    // receiver pacing: quiet stretches, random waits and one long hold-off
    int unsigned sink_cycle = 0;
    int unsigned sink_wait = 0;
    logic        sink_hold_long;
    logic        sink_quiet;

    always @(negedge clk) begin
        if (rst_n)
            sink_cycle <= sink_cycle + 1;
    end

    assign sink_hold_long = (sink_cycle >= 3000) && (sink_cycle < 3400);
    assign sink_quiet     = sink_cycle[8];

    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_took)
                sink_wait = sink_quiet ? 0 : $urandom_range(0, 14);
            if (sink_hold_long || sink_wait != 0) begin
                m_tready <= 1'b0;
                if (sink_wait != 0)
                    sink_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned total;
        int unsigned run_len;
        int unsigned kind;

        // directed: extremes, every access kind, pin and mode corner cases
        gap_max = 3;
        queue_access(FUNC_IO_RD,  16'h0000, 8'h00, 1'b0, 3'd0);
        queue_access(FUNC_IO_WR,  16'hab07, 8'hff, 1'b0, 3'd0);   // bank 0x7ff
        queue_access(FUNC_IO_RD,  16'h000f, 8'h00, 1'b0, 3'd0);
        queue_access(FUNC_IO_RD,  16'hff03, 8'h00, 1'b1, 3'd7);
        queue_access(FUNC_ROM_LO, 16'hffff, 8'h00, 1'b0, 3'd0);   // top flash address
        queue_access(FUNC_ROM_HI, 16'hfff8, 8'h00, 1'b0, 3'd0);
        queue_access(FUNC_ROM_HI, 16'hffff, 8'h00, 1'b0, 3'd0);
        queue_access(FUNC_ROM_HI, 16'hfff7, 8'h00, 1'b0, 3'd0);   // just below the vectors
        queue_access(FUNC_IO_RD,  16'h0010, 8'h00, 1'b0, 3'd0);   // unanswered
        queue_access(FUNC_IO_WR,  16'h0008, 8'h20, 1'b0, 3'd0);   // vectors, ultimax
        queue_access(FUNC_ROM_LO, 16'h1234, 8'h00, 1'b0, 3'd5);   // falls to machine memory
        queue_access(FUNC_ROM_LO, 16'h1234, 8'h00, 1'b0, 3'd7);
        queue_access(FUNC_ROM_LO, 16'h0000, 8'h00, 1'b0, 3'd3);
        queue_access(FUNC_IO_WR,  16'h0008, 8'h60, 1'b0, 3'd0);   // cartridge off wins
        queue_access(FUNC_IO_WR,  16'h0008, 8'ha0, 1'b0, 3'd0);   // bit-bang on
        queue_access(FUNC_IO_RD,  16'h0000, 8'h00, 1'b1, 3'd0);   // cs high: unanswered
        queue_access(FUNC_IO_WR,  16'h0000, 8'h30, 1'b0, 3'd0);   // select, clk=1, din=1
        queue_access(FUNC_IO_RD,  16'h00ff, 8'h00, 1'b1, 3'd0);
        queue_access(FUNC_IO_RD,  16'h0003, 8'h00, 1'b0, 3'd0);
        queue_access(FUNC_IO_WR,  16'h0020, 8'h00, 1'b0, 3'd0);   // no register, pins forwarded
        queue_access(FUNC_IO_WR,  16'h0003, 8'h40, 1'b0, 3'd0);   // deselect, pins hold
        queue_access(FUNC_IO_WR,  16'h0008, 8'hff, 1'b0, 3'd0);
        queue_access(FUNC_IO_WR,  16'h0008, 8'h00, 1'b0, 3'd0);
        queue_access(FUNC_IO_WR,  16'h0009, 8'hff, 1'b0, 3'd0);
        queue_access(FUNC_IO_RD,  16'h0008, 8'h00, 1'b0, 3'd0);

        // random: bank episodes, flash pin episodes and plain noise
        total = access_queue.size() + RANDOM_ITEMS;
        while (access_queue.size() < total) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            kind    = $urandom_range(0, 9);
            run_len = $urandom_range(4, 20);
            if (kind < 4) begin
                queue_access(FUNC_IO_WR, {8'($urandom), IO_CTRL_ADDR},
                             {1'b0, 7'($urandom)}, 1'($urandom), 3'($urandom));
                repeat (run_len) queue_random_access(1'b0);
            end else if (kind < 8) begin
                queue_access(FUNC_IO_WR, {8'($urandom), IO_CTRL_ADDR},
                             {1'b1, 7'($urandom)}, 1'($urandom), 3'($urandom));
                repeat (run_len) queue_random_access(1'b1);
            end else begin
                repeat (run_len)
                    queue_access(t_func'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                                 1'($urandom), 3'($urandom));
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (access_queue.size() != 0 || staged || s_tvalid)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cbspi_pkg.sv
hw/rtl/cartridge_bank_spi_bitbang_ctrl.sv
hw/rtl/cbspi_checker.sv
tb/cartridge_bank_spi_bitbang_ctrl_test.sv
